@@ hdl/bppd_pkg.sv @@
// Shared types and constants for the button press pattern decoder.
package bppd_pkg;

    localparam int CODE_DEPTH  = 4;
    localparam int CODE_IDX_W  = $clog2(CODE_DEPTH);
    localparam int COUNT_WIDTH = 10;
    localparam int LIMIT_W     = 10;
    localparam int TOTAL_W     = 4;
    localparam int CMD_W       = 3;
    localparam int CFG_IDX_W   = 1;

    localparam logic [COUNT_WIDTH-1:0] TICK_MAX  = {COUNT_WIDTH{1'b1}};
    localparam logic [TOTAL_W-1:0]     TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT  = 1'd1;

    localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST = 10'd30;
    localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST  = 10'd100;

    localparam logic CLS_SHORT = 1'b0;
    localparam logic CLS_LONG  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PRESS = 2'd1,
        PH_GAP   = 2'd2
    } t_phase;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE      = 3'd0,
        CMD_CALIBRATE = 3'd1,
        CMD_SAVE      = 3'd2,
        CMD_AUTOPLAY  = 3'd3,
        CMD_CLEAR     = 3'd4
    } t_cmd;

    typedef struct packed {
        t_cmd               command;
        logic               aborted;
        logic [TOTAL_W-1:0] press_count;
    } t_result;

endpackage

@@ hdl/button_press_pattern_decoder.sv @@
// Button press pattern decoder: times presses and gaps, classes them, matches patterns.
// Each result is registered in the output register, or in the skid if that holds an unread one.
// Throughput: one input beat per cycle unless stalled; presses and gaps cost nothing more.
// A two-entry result buffer (output register plus skid register) keeps input flowing while
// a result waits; input stalls only when both entries are full.
// Reset (i_rst_n low, synchronous) returns to idle, clears counters, classes and the
// buffer, and loads the limits with 30 and 100 ticks.
module button_press_pattern_decoder
    import bppd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIMIT_W-1:0]   i_cfg_wdata,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [0] button_pressed, [7:1] zero
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [2:0] command, [6:3] press_count, [7] zero
    output logic                 m_axis_tuser    // [0] aborted
);

    // limits
    logic [LIMIT_W-1:0] r_short_limit;
    logic [LIMIT_W-1:0] r_long_limit;

    // sequence state
    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_press_ticks, n_press_ticks;
    logic [COUNT_WIDTH-1:0] r_gap_ticks, n_gap_ticks;
    logic [CODE_DEPTH-1:0]  r_classes, n_classes;
    logic [TOTAL_W-1:0]     r_total, n_total;

    // result buffer
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic    accept, pressed, pop;
    logic    press_short, press_long, do_abort, do_finish, gap_end;
    logic    res_valid;
    t_result res;

    assign pressed       = s_axis_tdata[0];
    assign s_axis_tready = ~r_skid_valid;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign pop           = r_out_valid & m_axis_tready;

    // classify the press that ends on this beat; the short test wins over the long one
    assign press_short = r_press_ticks < r_short_limit;
    assign press_long  = r_press_ticks < r_long_limit;
    assign do_abort    = (r_phase == PH_PRESS) & ~pressed & ~press_short & ~press_long;

    function automatic t_cmd decode(input logic [CODE_DEPTH-1:0] cls,
                                    input logic [TOTAL_W-1:0]    total);
        t_cmd cmd;
        cmd = CMD_NONE;
        if (total == 4'd4 && cls[0] == CLS_SHORT && cls[1] == CLS_LONG
                && cls[2] == CLS_SHORT && cls[3] == CLS_LONG) begin
            cmd = CMD_CALIBRATE;
        end else if (total == 4'd1 && cls[0] == CLS_SHORT) begin
            cmd = CMD_SAVE;
        end else if (total == 4'd1 && cls[0] == CLS_LONG) begin
            cmd = CMD_AUTOPLAY;
        end else if (total == 4'd2 && cls[0] == CLS_SHORT && cls[1] == CLS_SHORT) begin
            cmd = CMD_CLEAR;
        end
        return cmd;
    endfunction

    // datapath: counters, class store and gap test
    always_comb begin
        n_press_ticks = r_press_ticks;
        n_gap_ticks   = r_gap_ticks;
        n_classes     = r_classes;
        n_total       = r_total;
        gap_end       = 1'b0;
        case (r_phase)
            PH_PRESS: begin
                if (pressed) begin
                    n_press_ticks = (r_press_ticks == TICK_MAX) ? TICK_MAX
                                  : r_press_ticks + 1'b1;
                end else if (do_abort) begin
                    n_press_ticks = '0;
                    n_gap_ticks   = '0;
                end else begin
                    // store class, open the gap as gap tick 1
                    if ({{(32-TOTAL_W){1'b0}}, r_total} < CODE_DEPTH) begin
                        n_classes[r_total[CODE_IDX_W-1:0]] = press_short ? CLS_SHORT
                                                                         : CLS_LONG;
                    end
                    n_total       = (r_total == TOTAL_MAX) ? TOTAL_MAX : r_total + 1'b1;
                    n_press_ticks = '0;
                    n_gap_ticks   = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
                    gap_end       = 1'b1;
                end
            end
            PH_GAP: begin
                if (pressed) begin
                    n_press_ticks = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
                    n_gap_ticks   = '0;
                end else begin
                    n_gap_ticks = (r_gap_ticks == TICK_MAX) ? TICK_MAX
                                : r_gap_ticks + 1'b1;
                    gap_end     = 1'b1;
                end
            end
            default: begin
                // idle and the unused code: a press opens a fresh sequence
                if (pressed) begin
                    n_classes     = '0;
                    n_total       = '0;
                    n_press_ticks = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
                    n_gap_ticks   = '0;
                end
            end
        endcase
        do_finish = gap_end && (n_gap_ticks >= r_long_limit);
        if (do_finish) begin
            n_gap_ticks = '0;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_PRESS: begin
                if (!pressed) begin
                    n_phase = (do_abort || do_finish) ? PH_IDLE : PH_GAP;
                end
            end
            PH_GAP: begin
                if (pressed) begin
                    n_phase = PH_PRESS;
                end else if (do_finish) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = pressed ? PH_PRESS : PH_IDLE;
            end
        endcase
    end

    // result of this beat
    always_comb begin
        res_valid       = do_abort | do_finish;
        res.command     = CMD_NONE;
        res.aborted     = 1'b0;
        res.press_count = n_total;
        if (do_abort) begin
            res.aborted     = 1'b1;
            res.press_count = (r_total == TOTAL_MAX) ? TOTAL_MAX : r_total + 1'b1;
        end else begin
            res.command = decode(n_classes, n_total);
        end
    end

    // configuration and sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_limit <= SHORT_LIMIT_RST;
            r_long_limit  <= LONG_LIMIT_RST;
            r_phase       <= PH_IDLE;
            r_press_ticks <= '0;
            r_gap_ticks   <= '0;
            r_classes     <= '0;
            r_total       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_SHORT_LIMIT) begin
                    r_short_limit <= i_cfg_wdata;
                end else if (i_cfg_index == CFG_LONG_LIMIT) begin
                    r_long_limit <= i_cfg_wdata;
                end
            end
            if (accept) begin
                r_phase       <= n_phase;
                r_press_ticks <= n_press_ticks;
                r_gap_ticks   <= n_gap_ticks;
                r_classes     <= n_classes;
                r_total       <= n_total;
            end
        end
    end

    // result buffer: drain skid first, otherwise load output or park in skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (accept && res_valid) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (accept && res_valid) begin
            if (!r_out_valid || pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.press_count, r_out.command};
    assign m_axis_tuser  = r_out.aborted;

endmodule
